### hdl/bitmap_first_fit_allocator_top_macros.svh
// Assertion macros for the verification files of the allocator.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BFFA_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Clocked assertion that must also hold while reset is held.
`define BFFA_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

### hdl/bffa_pkg.sv
package bffa_pkg;

    // Request kinds carried on the input side.
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FAIL  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_DONE = 2'd2
    } fsm_t;

    // Fixed field widths of the request and result.
    localparam int START_W = 8;
    localparam int LEN_W   = 9;
    localparam int USED_W  = 9;

    // Contents of one map cell: the allocation bit and a tentative mark that
    // flags a unit belonging to the free run currently being measured.
    typedef struct packed {
        logic used;
        logic tent;
    } cell_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic shift;
        logic commit;
        logic cancel;
        logic clear;
    } ctrl_t;

endpackage

### hdl/bffa_cell.sv
module bffa_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  bffa_pkg::ctrl_t ctl,
    input  bffa_pkg::cell_t nb,
    output bffa_pkg::cell_t q
);
    import bffa_pkg::*;

    cell_t q_reg;
    cell_t q_next;

    // While the ring turns, a commit turns a tentative unit into a used one
    // and a cancel drops the tentative mark.
    always_comb
    begin
        q_next = q_reg;
        if (ctl.clear)
        begin
            q_next = '0;
        end
        else if (ctl.shift)
        begin
            q_next.used = nb.used | (ctl.commit & nb.tent);
            q_next.tent = nb.tent & ~ctl.commit & ~ctl.cancel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### hdl/bffa_ctrl.sv
module bffa_ctrl #(
    parameter int UNITS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       in_op,
    input  logic [bffa_pkg::START_W-1:0]     in_start,
    input  logic [bffa_pkg::LEN_W-1:0]       in_len,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       out_status,
    output logic [bffa_pkg::START_W-1:0]     out_start,
    output logic [bffa_pkg::USED_W-1:0]      out_used,
    input  bffa_pkg::cell_t                  head,
    output bffa_pkg::cell_t                  tail,
    output bffa_pkg::ctrl_t                  ctl
);
    import bffa_pkg::*;

    localparam int IW = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CW = $clog2(UNITS + 1);
    localparam int EW = (CW > 10) ? CW : 10;

    fsm_t                  state_reg, state_next;
    logic [1:0]            op_reg;
    logic [START_W-1:0]    start_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [IW-1:0]         step_reg;
    logic [CW-1:0]         run_reg;
    logic                  found_reg;
    logic [START_W-1:0]    gstart_reg;
    logic [CW-1:0]         used_reg;
    logic [1:0]            res_status_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [START_W-1:0]    out_start_reg;
    logic [USED_W-1:0]     out_used_reg;

    logic [EW-1:0] in_len_e, in_start_e, free_e, used_e, sub_e;
    logic [EW-1:0] len_e, step_e, range_end_e, gstart_e;
    logic [CW-1:0] run_inc;
    logic          alloc_bad, oob, immediate, last, hit, in_range, load_out;

    // Request decode and up-front checks.
    always_comb
    begin
        in_len_e   = EW'(in_len);
        in_start_e = EW'(in_start);
        used_e     = EW'(used_reg);
        free_e     = EW'(UNITS) - used_e;
        alloc_bad  = (in_len == '0) || (in_len_e > free_e);
        oob        = (in_start_e + in_len_e) > EW'(UNITS);
        sub_e      = (used_e >= in_len_e) ? (used_e - in_len_e) : '0;
        case (op_t'(in_op))
            OP_ALLOC: immediate = alloc_bad;
            OP_FREE:  immediate = oob;
            default:  immediate = 1'b1;
        endcase
    end

    // Scan datapath around the head of the ring.
    always_comb
    begin
        len_e       = EW'(len_reg);
        step_e      = EW'(step_reg);
        range_end_e = EW'(start_reg) + len_e;
        run_inc     = run_reg + CW'(1);
        last        = (step_reg == IW'(UNITS - 1));
        hit         = (op_reg == OP_ALLOC) && !found_reg && !head.used
                      && (EW'(run_inc) == len_e);
        in_range    = (step_e >= EW'(start_reg)) && (step_e < range_end_e);
        gstart_e    = step_e + EW'(1) - len_e;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = immediate ? FSM_DONE : FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (last)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, cell controls and the unit that
    // re-enters the ring at its tail.
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        ctl      = '0;
        tail     = head;
        case (state_reg)
            FSM_IDLE:
            begin
                in_ready  = 1'b1;
                ctl.clear = in_valid && (in_op == OP_CLEAR);
            end
            FSM_SCAN:
            begin
                ctl.shift = 1'b1;
                if (op_reg == OP_ALLOC && !found_reg)
                begin
                    tail.tent = 1'b0;
                    if (head.used)
                    begin
                        ctl.cancel = 1'b1;
                    end
                    else if (hit)
                    begin
                        ctl.commit = 1'b1;
                        tail.used  = 1'b1;
                    end
                    else if (last)
                    begin
                        ctl.cancel = 1'b1;
                    end
                    else
                    begin
                        tail.tent = 1'b1;
                    end
                end
                else if (op_reg == OP_FREE && in_range)
                begin
                    tail.used = 1'b0;
                end
            end
            FSM_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            used_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FSM_IDLE && in_valid)
            begin
                found_reg <= 1'b0;
                case (op_t'(in_op))
                    OP_FREE:
                    begin
                        if (!oob)
                        begin
                            used_reg <= CW'(sub_e);
                        end
                    end
                    OP_CLEAR: used_reg <= '0;
                    default: ;
                endcase
            end
            else if (state_reg == FSM_SCAN && hit)
            begin
                found_reg <= 1'b1;
                used_reg  <= CW'(used_e + len_e);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && in_valid)
        begin
            op_reg     <= in_op;
            start_reg  <= in_start;
            len_reg    <= in_len;
            step_reg   <= '0;
            run_reg    <= '0;
            gstart_reg <= '0;
            case (op_t'(in_op))
                OP_ALLOC: res_status_reg <= alloc_bad ? STS_FAIL : STS_OK;
                OP_FREE:  res_status_reg <= oob ? STS_RANGE : STS_OK;
                default:  res_status_reg <= STS_OK;
            endcase
        end
        else if (state_reg == FSM_SCAN)
        begin
            step_reg <= step_reg + IW'(1);
            run_reg  <= head.used ? '0 : run_inc;
            if (hit)
            begin
                gstart_reg <= gstart_e[START_W-1:0];
            end
            else if (op_reg == OP_ALLOC && last && !found_reg)
            begin
                res_status_reg <= STS_FAIL;
            end
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= gstart_reg;
            out_used_reg   <= used_e[USED_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;
    assign out_used   = out_used_reg;

endmodule

### hdl/bitmap_first_fit_allocator_top.sv
// Bitmap first-fit allocator: keeps one allocation bit per unit in a ring of
// UNITS small cells and a count of used units. For an allocate or free request
// the ring turns exactly once, one unit per cycle past the scan logic at its
// head, and then the result moves into the output register. The block then
// accepts the next request. A clear, a rejected request or an unknown operation
// skips the ring turn and moves its result straight into the output register.
// One request is worked on at a time. The next one is accepted as soon as the
// previous result sits in the output register, even if the downstream side has
// not taken it yet.
module bitmap_first_fit_allocator_top #(
    parameter int UNITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] run_start, [16:8] run_length, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] granted_start, [16:8] units_in_use, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import bffa_pkg::*;

    // The ring: cell k takes its neighbor k+1 each scan cycle, and the unit
    // leaving cell 0 (the head) comes back in at the last cell, possibly
    // updated by the sequencer.
    cell_t              ring [UNITS];
    cell_t              tail;
    ctrl_t              ctl;
    logic [START_W-1:0] granted_start;
    logic [USED_W-1:0]  units_in_use;
    logic [1:0]         status;

    for (genvar k = 0; k < UNITS; k++)
    begin : g_cell
        if (k == UNITS - 1)
        begin : g_tail
            bffa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .nb    (tail),
                .q     (ring[k])
            );
        end
        else
        begin : g_body
            bffa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .nb    (ring[k+1]),
                .q     (ring[k])
            );
        end
    end

    // The sequencer holds the request, the run counter, the used-unit count
    // and the output register.
    bffa_ctrl #(
        .UNITS (UNITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_start   (s_axis_tdata[7:0]),
        .in_len     (s_axis_tdata[16:8]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_start  (granted_start),
        .out_used   (units_in_use),
        .head       (ring[0]),
        .tail       (tail),
        .ctl        (ctl)
    );

    assign m_axis_tdata = {7'd0, units_in_use, granted_start};
    assign m_axis_tuser = status;

endmodule

### hdl/bffa_checker.sv
`include "bitmap_first_fit_allocator_top_macros.svh"

module bffa_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import bffa_pkg::*;

    // A stalled result holds still.
    `BFFA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // After a request is taken the block is busy in the next cycle.
    `BFFA_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")

    // Only the three defined status codes are ever reported.
    `BFFA_ASSERT_ALWAYS(a_status_code, m_axis_tvalid |-> m_axis_tuser != 2'd3, "undefined status code")

    // A failed request never reports a granted start.
    `BFFA_ASSERT(a_fail_no_start, m_axis_tvalid && m_axis_tuser != STS_OK |-> m_axis_tdata[7:0] == 8'd0, "start reported on failure")

endmodule

bind bitmap_first_fit_allocator_top bffa_props u_bffa_props (.*);

### tb/bffa_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the allocator, keeps its own copy of the allocation
// map and the used count, and compares every result with the oldest
// outstanding prediction.
module bffa_checker #(
    parameter int UNITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending,
    output int          checked
);
    import bffa_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [START_W-1:0] start;
        logic [USED_W-1:0]  used;
    } alloc_reply_t;

    logic [UNITS-1:0]  unit_map;
    logic [USED_W-1:0] used_units;
    alloc_reply_t      reply_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    // Applies one request to the shadow map and returns the reply it earns.
    function automatic alloc_reply_t apply_request(input logic [1:0] op,
                                                   input logic [START_W-1:0] start,
                                                   input logic [LEN_W-1:0] len);
        alloc_reply_t r;
        int run;
        int first;
        int i;
        int k;
        bit found;
        r.status = STS_OK;
        r.start  = '0;
        case (op)
            OP_ALLOC:
            begin
                if (len == 0 || int'(len) > UNITS - int'(used_units))
                begin
                    r.status = STS_FAIL;
                end
                else
                begin
                    run   = 0;
                    found = 1'b0;
                    for (i = 0; i < UNITS && !found; i++)
                    begin
                        if (unit_map[i])
                        begin
                            run = 0;
                        end
                        else
                        begin
                            run++;
                            if (run == int'(len))
                            begin
                                first = i + 1 - int'(len);
                                for (k = first; k <= i; k++) unit_map[k] = 1'b1;
                                used_units = used_units + len;
                                r.start = first[START_W-1:0];
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) r.status = STS_FAIL;
                end
            end
            OP_FREE:
            begin
                if (int'(start) + int'(len) > UNITS)
                begin
                    r.status = STS_RANGE;
                end
                else
                begin
                    for (k = int'(start); k < int'(start) + int'(len); k++) unit_map[k] = 1'b0;
                    used_units = (used_units >= len) ? used_units - len : '0;
                end
            end
            OP_CLEAR:
            begin
                unit_map   = '0;
                used_units = '0;
            end
            default:
            begin
                // Unknown code: state is left alone and the count is reported.
            end
        endcase
        r.used = used_units;
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_reply_t want;
        if (!rst_n)
        begin
            unit_map   = '0;
            used_units = '0;
            reply_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_request(s_tuser, s_tdata[7:0], s_tdata[16:8]));
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected result: status %0d, granted_start %0d, units_in_use %0d",
                           m_tuser, m_tdata[7:0], m_tdata[16:8]);
                    errors++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    checked++;
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.start)
                    begin
                        $error("granted_start: expected %0d, actual %0d",
                               want.start, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[16:8] !== want.used)
                    begin
                        $error("units_in_use: expected %0d, actual %0d",
                               want.used, m_tdata[16:8]);
                        errors++;
                    end
                end
            end
        end
        pending <= reply_q.size();
    end

endmodule

### tb/bitmap_first_fit_allocator_top_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the first-fit allocator. Requests are driven on the
// input stream and results drained on the output stream; the checker module
// beside the block does all prediction and comparison.
module bitmap_first_fit_allocator_top_tb;
    import bffa_pkg::*;

    localparam int UNITS           = 256;
    // Random requests after the directed opening, split into three idling phases.
    localparam int RANDOM_REQUESTS = 1880;
    localparam int PHASE_LEN       = RANDOM_REQUESTS / 3;
    // Unknown operation code, not part of the package enum.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES     = 800;
    // The tail leaves room for one more allocate or free after the last result.
    localparam int TAIL_CYCLES     = UNITS + 50;
    // The longest correct quiet stretch is one full ring turn plus the hold-off
    // plus a random receiver stall; the limit is several times that.
    localparam int WATCHDOG_LIMIT  = 4 * (UNITS + 2 + HOLD_CYCLES + 100);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [7:0] run_start, [16:8] run_length, rest zero
    logic [1:0]  s_axis_tuser = '0;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] granted_start, [16:8] units_in_use, rest zero
    logic [1:0]  m_axis_tuser;         // [1:0] status

    int errors;
    int pending;
    int checked;

    // Idle percentages: the sender's is only used by the stimulus process, the
    // receiver's is handed over with nonblocking writes.
    int tx_idle_pct = 12;
    int rx_idle_pct = 73;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    // Request counts per operation, for the closing summary.
    int n_alloc = 0;
    int n_free = 0;
    int n_clear = 0;
    int n_unused = 0;

    // Bookkeeping of live allocations, so that most frees release real runs.
    logic [1:0]  sent_op_q[$];
    logic [8:0]  sent_len_q[$];
    logic [7:0]  live_start_q[$];
    logic [8:0]  live_len_q[$];

    always #4 clk = ~clk;

    bitmap_first_fit_allocator_top #(
        .UNITS(UNITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bffa_checker #(
        .UNITS(UNITS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // Offers one request, idling first at the sender's current rate, and
    // returns at the edge where it is accepted. Valid only drops when an idle
    // cycle is actually taken, so it never gets two writes in one step.
    task automatic send_request(input logic [1:0] op, input logic [7:0] start,
                                input logic [8:0] len);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, len, start};
        case (op)
            OP_ALLOC: n_alloc++;
            OP_FREE:  n_free++;
            OP_CLEAR: n_clear++;
            default:  n_unused++;
        endcase
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Receiver: random stalls at the current rate, and once a single long
    // hold-off counted here while the sender keeps offering requests.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Pair each result with its request: a granted allocate becomes a live run,
    // a clear drops every live run.
    always @(posedge clk)
    begin
        logic [1:0] op;
        logic [8:0] len;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent_op_q.push_back(s_axis_tuser);
                sent_len_q.push_back(s_axis_tdata[16:8]);
            end
            if (m_axis_tvalid && m_axis_tready && sent_op_q.size() != 0)
            begin
                op  = sent_op_q.pop_front();
                len = sent_len_q.pop_front();
                if (op == OP_ALLOC && m_axis_tuser == STS_OK)
                begin
                    live_start_q.push_back(m_axis_tdata[7:0]);
                    live_len_q.push_back(len);
                end
                else if (op == OP_CLEAR)
                begin
                    live_start_q.delete();
                    live_len_q.delete();
                end
            end
        end
    end

    // Watchdog on cycles in which neither stream moves anything.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int n;
        int pick;
        int idx;
        logic [1:0] op;
        logic [7:0] start;
        logic [8:0] len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: field extremes and each corner of the behavior.
        send_request(OP_ALLOC, 8'd0, 9'd0);       // zero-length allocate fails
        send_request(OP_ALLOC, 8'd0, 9'd256);     // whole map in one run
        send_request(OP_ALLOC, 8'd0, 9'd1);       // too few free units
        send_request(OP_FREE, 8'd0, 9'd256);      // free ending exactly at the top
        send_request(OP_ALLOC, 8'd0, 9'd1);
        send_request(OP_ALLOC, 8'd0, 9'd3);
        send_request(OP_FREE, 8'd0, 9'd1);        // leaves a one-unit hole at unit 0
        send_request(OP_ALLOC, 8'd0, 9'd2);       // hole too small, goes past it
        send_request(OP_ALLOC, 8'd0, 9'd1);       // fills the hole
        send_request(OP_FREE, 8'd255, 9'd1);      // free of a unit already free
        send_request(OP_FREE, 8'd255, 9'd2);      // range past the end
        send_request(OP_FREE, 8'd10, 9'd0);       // zero-length free
        send_request(OP_UNUSED, 8'hff, 9'h1ff);   // unknown code is ignored
        send_request(OP_ALLOC, 8'd0, 9'd250);
        send_request(OP_ALLOC, 8'd0, 9'd1);       // count says room, map has no run
        send_request(OP_FREE, 8'd200, 9'd56);
        send_request(OP_FREE, 8'd255, 9'h1ff);    // length beyond the map size
        send_request(OP_ALLOC, 8'd0, 9'h1ff);
        send_request(OP_FREE, 8'd0, 9'd300);
        send_request(OP_CLEAR, 8'd0, 9'd0);
        send_request(OP_FREE, 8'd0, 9'd5);        // count saturates at zero
        send_request(OP_ALLOC, 8'd0, 9'd256);
        send_request(OP_CLEAR, 8'hff, 9'h1ff);

        // Random part: mostly allocates and frees of live runs, with some
        // arbitrary frees, clears and unknown codes as noise.
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == PHASE_LEN)
            begin
                tx_idle_pct = 73;
                rx_idle_pct <= 12;
            end
            else if (n == 2 * PHASE_LEN)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (n == 2 * PHASE_LEN + 40) hold_request <= 1'b1;

            start = 8'($urandom_range(255));
            len   = '0;
            pick  = $urandom_range(99);
            if (pick < 46)
            begin
                op   = OP_ALLOC;
                pick = $urandom_range(99);
                if (pick < 70)      len = 9'($urandom_range(8, 1));
                else if (pick < 88) len = 9'($urandom_range(48, 9));
                else if (pick < 97) len = 9'($urandom_range(256, 49));
                else if (pick < 99) len = 9'd256;
                else                len = 9'd0;
            end
            else if (pick < 83 && live_start_q.size() != 0)
            begin
                op    = OP_FREE;
                idx   = $urandom_range(live_start_q.size() - 1);
                start = live_start_q[idx];
                len   = live_len_q[idx];
                live_start_q.delete(idx);
                live_len_q.delete(idx);
            end
            else if (pick < 95)
            begin
                op  = OP_FREE;
                len = ($urandom_range(19) == 0) ? 9'($urandom_range(511))
                                                : 9'($urandom_range(32));
            end
            else if (pick < 98)
            begin
                op = OP_CLEAR;
            end
            else
            begin
                op  = OP_UNUSED;
                len = 9'($urandom_range(511));
            end
            send_request(op, start, len);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted result, then one more ring turn so a
        // stray result would still be seen.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending != 0) $error("%0d predicted results never arrived", pending);
        $display("Sent %0d allocate, %0d free, %0d clear and %0d unknown requests; %0d results checked.",
                 n_alloc, n_free, n_clear, n_unused, checked);
        $display("Sender and receiver idled in turn, then neither, with one long output hold-off.");
        if (errors == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
